// ----- design/wall_follower_maze_step_top_defines.svh -----
// ----------------------------------------------------------------------------
// Wall follower maze step - assertion macros
// Shared property wrappers clocked on i_clk, used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WALL_FOLLOWER_MAZE_STEP_TOP_DEFINES_SVH
`define WALL_FOLLOWER_MAZE_STEP_TOP_DEFINES_SVH

// property checked outside reset
`define WFMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge
`define WFMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/wfms_pkg.sv -----
// ----------------------------------------------------------------------------
// Wall follower maze step - package
// Codes, register map and the control/status structs shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wfms_pkg;

    localparam logic [1:0] MODE_RESTART = 2'd0;
    localparam logic [1:0] MODE_STEP    = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    localparam logic [2:0] ACT_RIGHT = 3'd0;
    localparam logic [2:0] ACT_AHEAD = 3'd1;
    localparam logic [2:0] ACT_LEFT  = 3'd2;
    localparam logic [2:0] ACT_BACK  = 3'd3;
    localparam logic [2:0] ACT_NONE  = 3'd4;

    localparam logic [1:0] MARK_UNVISITED = 2'd0;
    localparam logic [1:0] MARK_PATH      = 2'd1;
    localparam logic [1:0] MARK_DISCARDED = 2'd2;

    localparam logic [1:0] HEAD_TOP    = 2'd0;
    localparam logic [1:0] HEAD_RIGHT  = 2'd1;
    localparam logic [1:0] HEAD_BOTTOM = 2'd2;
    localparam logic [1:0] HEAD_LEFT   = 2'd3;

    localparam logic [1:0] REG_MAZE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAZE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_START_HEADING = 2'd2;

    localparam logic [6:0] RST_MAZE_WIDTH    = 7'd64;
    localparam logic [6:0] RST_MAZE_HEIGHT   = 7'd64;
    localparam logic [1:0] RST_START_HEADING = 2'd0;

    typedef struct packed {
        logic [6:0] maze_width;
        logic [6:0] maze_height;
        logic [1:0] start_heading;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic calc;
        logic rd;
        logic wr;
        logic clear;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_restart;
        logic clr_last;
    } t_sts;

endpackage

`default_nettype wire

// ----- design/wall_follower_maze_step_top.sv -----
// ----------------------------------------------------------------------------
// Wall follower maze step - top level
// Right-hand wall follower with a per-cell mark memory.
//
// Input stream: tuser carries the mode (restart, step, read mark), tdata the
// wall bits of the current cell and the cell index for a mark read. Every
// item gives exactly one result item on the output stream.
// Step and read items pass through accept, decision and cell-index multiply,
// mark memory read, mark update and result load. A restart item sweeps all
// MAX_SIDE*MAX_SIDE entries (4096 at the default) of the mark memory at one
// entry per cycle through the single write port, then delivers its result.
// Reset clears the walker to cell 0 with heading top, restores register defaults
// and runs the same clearing sweep; tready stays low during it. The user writes
// configuration over the APB port only while no item is in flight; the block does
// not enforce it. A stalled receiver holds the result in the output register;
// the block finishes the next item and then waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_follower_maze_step_top #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // [3:0] wall_bits, [15:4] cell_index
    input  wire logic [1:0]  i_s_axis_tuser,  // [1:0] mode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // [11:0] position, [13:12] heading,
                                              // [16:14] action, [17] solved,
                                              // [18] blocked, [20:19] cell_mark
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    wfms_pkg::t_cfg cfg;
    wfms_pkg::t_cmd cmd;
    wfms_pkg::t_sts sts;

    logic [11:0] position;
    logic [1:0]  heading;
    logic [2:0]  action;
    logic        solved;
    logic        blocked;
    logic [1:0]  cell_mark;

    wfms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wfms_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    wfms_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_s_axis_tuser),
        .i_wall_bits  (i_s_axis_tdata[3:0]),
        .i_cell_index (i_s_axis_tdata[15:4]),
        .o_position   (position),
        .o_heading    (heading),
        .o_action     (action),
        .o_solved     (solved),
        .o_blocked    (blocked),
        .o_cell_mark  (cell_mark)
    );

    assign o_m_axis_tdata = {3'd0, cell_mark, blocked, solved, action, heading, position};

endmodule

`default_nettype wire

// ----- design/wfms_cfg.sv -----
// ----------------------------------------------------------------------------
// Wall follower maze step - configuration registers
// APB-style register file: maze width, maze height and start heading.
// ----------------------------------------------------------------------------
`default_nettype none

module wfms_cfg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output wfms_pkg::t_cfg       o_cfg
);

    wfms_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.maze_width    <= wfms_pkg::RST_MAZE_WIDTH;
            r_cfg.maze_height   <= wfms_pkg::RST_MAZE_HEIGHT;
            r_cfg.start_heading <= wfms_pkg::RST_START_HEADING;
        end else if (wr_en) begin
            case (reg_idx)
                wfms_pkg::REG_MAZE_WIDTH:    r_cfg.maze_width    <= pwdata[6:0];
                wfms_pkg::REG_MAZE_HEIGHT:   r_cfg.maze_height   <= pwdata[6:0];
                wfms_pkg::REG_START_HEADING: r_cfg.start_heading <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            wfms_pkg::REG_MAZE_WIDTH:    prdata = {25'd0, r_cfg.maze_width};
            wfms_pkg::REG_MAZE_HEIGHT:   prdata = {25'd0, r_cfg.maze_height};
            wfms_pkg::REG_START_HEADING: prdata = {30'd0, r_cfg.start_heading};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/wfms_ctrl.sv -----
// ----------------------------------------------------------------------------
// Wall follower maze step - controller
// Sequences clear sweep, decision, mark read, mark update and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module wfms_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_valid,
    output logic                 o_s_ready,
    output logic                 o_m_valid,
    input  wire logic            i_m_ready,
    output wfms_pkg::t_cmd       o_cmd,
    input  wire wfms_pkg::t_sts  i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_RD,
        S_WR,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_item, n_clr_item;
    logic   r_out_valid, n_out_valid;
    logic   r_ready, n_ready;

    always_comb begin
        n_state     = r_state;
        n_clr_item  = r_clr_item;
        n_out_valid = r_out_valid && !i_m_ready;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state    = r_clr_item ? S_OUT : S_IDLE;
                    n_clr_item = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                if (i_sts.is_restart) begin
                    n_state    = S_CLEAR;
                    n_clr_item = 1'b1;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ready     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_item  <= n_clr_item;
            r_out_valid <= n_out_valid;
            r_ready     <= n_ready;
        end
    end

    assign o_s_ready = r_ready;
    assign o_m_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- design/wfms_dpath.sv -----
// ----------------------------------------------------------------------------
// Wall follower maze step - datapath
// Walker position and heading, turn choice, edge check, mark memory and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wfms_dpath #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire wfms_pkg::t_cfg  i_cfg,
    input  wire wfms_pkg::t_cmd  i_cmd,
    output wfms_pkg::t_sts       o_sts,
    input  wire logic [1:0]      i_mode,
    input  wire logic [3:0]      i_wall_bits,
    input  wire logic [11:0]     i_cell_index,
    output logic [11:0]          o_position,
    output logic [1:0]           o_heading,
    output logic [2:0]           o_action,
    output logic                 o_solved,
    output logic                 o_blocked,
    output logic [1:0]           o_cell_mark
);

    localparam int SW    = $clog2(MAX_SIDE);
    localparam int EW    = $clog2(MAX_SIDE + 1);
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = AW + 1;

    // walker state
    logic [SW-1:0] r_col, r_row;
    logic [1:0]    r_heading;

    // latched item
    logic [1:0]  r_mode;
    logic [3:0]  r_walls;
    logic [11:0] r_query;

    // decision stage
    logic [AW-1:0] r_prev_cell, r_last, r_new_cell;
    logic [SW-1:0] r_ncol, r_nrow;
    logic [1:0]    r_nh;
    logic [2:0]    r_act;
    logic          r_go, r_blocked;

    // read stage
    logic          r_step_ok, r_qvalid;
    logic [1:0]    r_rdata;

    // result
    logic [AW-1:0] r_res_pos;
    logic [1:0]    r_res_hd;
    logic [2:0]    r_res_act;
    logic          r_res_blk;
    logic [1:0]    r_res_mark;

    logic [AW-1:0] r_clr_cnt;
    logic [1:0]    r_mark [CELLS];

    logic [EW-1:0] w_eff, h_eff;
    logic [1:0]    hd_rt, hd_lt, c_nh;
    logic [2:0]    c_act;
    logic          c_move, c_blocked;
    logic [SW-1:0] c_ncol, c_nrow;
    logic [PW-1:0] prod_prev, prod_wh;
    logic [AW-1:0] c_new_cell, rd_addr, wr_addr;
    logic [1:0]    wr_data;
    logic          clr_last;

    always_comb begin
        if (i_cfg.maze_width == '0) begin
            w_eff = EW'(1);
        end else if (32'(i_cfg.maze_width) > MAX_SIDE) begin
            w_eff = EW'(MAX_SIDE);
        end else begin
            w_eff = EW'(i_cfg.maze_width);
        end
        if (i_cfg.maze_height == '0) begin
            h_eff = EW'(1);
        end else if (32'(i_cfg.maze_height) > MAX_SIDE) begin
            h_eff = EW'(MAX_SIDE);
        end else begin
            h_eff = EW'(i_cfg.maze_height);
        end
    end

    // right, ahead, left, back
    assign hd_rt = r_heading + 2'd1;
    assign hd_lt = r_heading - 2'd1;

    always_comb begin
        if (!r_walls[hd_rt]) begin
            c_act  = wfms_pkg::ACT_RIGHT;
            c_nh   = hd_rt;
            c_move = 1'b1;
        end else if (!r_walls[r_heading]) begin
            c_act  = wfms_pkg::ACT_AHEAD;
            c_nh   = r_heading;
            c_move = 1'b1;
        end else if (!r_walls[hd_lt]) begin
            c_act  = wfms_pkg::ACT_LEFT;
            c_nh   = hd_lt;
            c_move = 1'b1;
        end else begin
            c_act  = wfms_pkg::ACT_BACK;
            c_nh   = r_heading + 2'd2;
            c_move = 1'b0;
        end
    end

    always_comb begin
        c_ncol    = r_col;
        c_nrow    = r_row;
        c_blocked = 1'b0;
        case (c_nh)
            wfms_pkg::HEAD_TOP: begin
                if (r_row == '0) c_blocked = 1'b1;
                else c_nrow = r_row - SW'(1);
            end
            wfms_pkg::HEAD_RIGHT: begin
                if (32'(r_col) + 32'd1 >= 32'(w_eff)) c_blocked = 1'b1;
                else c_ncol = r_col + SW'(1);
            end
            wfms_pkg::HEAD_BOTTOM: begin
                if (32'(r_row) + 32'd1 >= 32'(h_eff)) c_blocked = 1'b1;
                else c_nrow = r_row + SW'(1);
            end
            wfms_pkg::HEAD_LEFT: begin
                if (r_col == '0) c_blocked = 1'b1;
                else c_ncol = r_col - SW'(1);
            end
            default: c_blocked = 1'b1;
        endcase
        if (!c_move) begin
            c_ncol    = r_col;
            c_nrow    = r_row;
            c_blocked = 1'b0;
        end
    end

    assign prod_prev = PW'(r_row) * PW'(w_eff) + PW'(r_col);
    assign prod_wh   = PW'(w_eff) * PW'(h_eff);

    // neighbor cell from the current one
    always_comb begin
        c_new_cell = r_prev_cell;
        if (r_go) begin
            case (r_nh)
                wfms_pkg::HEAD_TOP:    c_new_cell = r_prev_cell - AW'(w_eff);
                wfms_pkg::HEAD_RIGHT:  c_new_cell = r_prev_cell + AW'(1);
                wfms_pkg::HEAD_BOTTOM: c_new_cell = r_prev_cell + AW'(w_eff);
                wfms_pkg::HEAD_LEFT:   c_new_cell = r_prev_cell - AW'(1);
                default:               c_new_cell = r_prev_cell;
            endcase
        end
    end

    assign rd_addr = (r_mode == wfms_pkg::MODE_READ) ? AW'(r_query) : c_new_cell;
    assign wr_addr = (r_rdata == wfms_pkg::MARK_PATH) ? r_prev_cell : r_new_cell;
    assign wr_data = (r_rdata == wfms_pkg::MARK_PATH) ? wfms_pkg::MARK_DISCARDED
                                                      : wfms_pkg::MARK_PATH;
    assign clr_last = (r_clr_cnt == AW'(CELLS - 1));

    assign o_sts.is_restart = (r_mode == wfms_pkg::MODE_RESTART);
    assign o_sts.clr_last   = clr_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mark[r_clr_cnt] <= (r_clr_cnt == '0) ? wfms_pkg::MARK_PATH
                                                   : wfms_pkg::MARK_UNVISITED;
        end else if (i_cmd.wr && r_step_ok && r_go) begin
            r_mark[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mark[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= clr_last ? '0 : r_clr_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_heading <= wfms_pkg::RST_START_HEADING;
        end else if (i_cmd.calc && r_mode == wfms_pkg::MODE_RESTART) begin
            r_col     <= '0;
            r_row     <= '0;
            r_heading <= i_cfg.start_heading;
        end else if (i_cmd.wr && r_step_ok) begin
            r_heading <= r_nh;
            if (r_go) begin
                r_col <= r_ncol;
                r_row <= r_nrow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= i_mode;
            r_walls <= i_wall_bits;
            r_query <= i_cell_index;
        end
        if (i_cmd.calc) begin
            r_prev_cell <= AW'(prod_prev);
            r_last      <= AW'(prod_wh - PW'(1));
            r_ncol      <= c_ncol;
            r_nrow      <= c_nrow;
            r_nh        <= c_nh;
            r_act       <= c_act;
            r_go        <= c_move && !c_blocked;
            r_blocked   <= c_blocked;
            if (r_mode == wfms_pkg::MODE_RESTART) begin
                r_res_pos  <= '0;
                r_res_hd   <= i_cfg.start_heading;
                r_res_act  <= wfms_pkg::ACT_NONE;
                r_res_blk  <= 1'b0;
                r_res_mark <= wfms_pkg::MARK_UNVISITED;
            end
        end
        if (i_cmd.rd) begin
            r_new_cell <= c_new_cell;
            r_step_ok  <= (r_mode == wfms_pkg::MODE_STEP) && (r_prev_cell != r_last);
            r_qvalid   <= (r_mode == wfms_pkg::MODE_READ) && (32'(r_query) < CELLS);
        end
        if (i_cmd.wr) begin
            r_res_pos  <= (r_step_ok && r_go) ? r_new_cell : r_prev_cell;
            r_res_hd   <= r_step_ok ? r_nh : r_heading;
            r_res_act  <= r_step_ok ? r_act : wfms_pkg::ACT_NONE;
            r_res_blk  <= r_step_ok && r_blocked;
            r_res_mark <= r_qvalid ? r_rdata : wfms_pkg::MARK_UNVISITED;
        end
        if (i_cmd.load_out) begin
            o_position  <= 12'(r_res_pos);
            o_heading   <= r_res_hd;
            o_action    <= r_res_act;
            o_solved    <= (r_res_pos == r_last);
            o_blocked   <= r_res_blk;
            o_cell_mark <= r_res_mark;
        end
    end

endmodule

`default_nettype wire

// ----- design/wfms_checker.sv -----
// ----------------------------------------------------------------------------
// Wall follower maze step - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wall_follower_maze_step_top_defines.svh"

module wfms_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata
);

    `WFMS_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    `WFMS_ASSERT(a_one_item, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "item accepted while another in flight")

    `WFMS_ASSERT(a_none_unblocked, o_m_axis_tvalid && (o_m_axis_tdata[16:14] == wfms_pkg::ACT_NONE) |-> !o_m_axis_tdata[18], "blocked flagged without a move")

    `WFMS_ASSERT_ALWAYS(a_mark_no_move, !i_rst_n || !o_m_axis_tvalid || (o_m_axis_tdata[20:19] == wfms_pkg::MARK_UNVISITED) || (o_m_axis_tdata[16:14] == wfms_pkg::ACT_NONE), "cell mark on a step result")

endmodule

bind wall_follower_maze_step_top wfms_checker u_checker (.*);

`default_nettype wire
